// File: rtl/characteristic_to_conserved_transform_defines.svh
// Assertion macros for the characteristic-to-conserved transform block.
`ifndef CHARACTERISTIC_TO_CONSERVED_TRANSFORM_DEFINES_SVH
`define CHARACTERISTIC_TO_CONSERVED_TRANSFORM_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, off during rst
`define CTC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CTC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CTC_ASSERT_IMP(label, ante, cons, msg)
`define CTC_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/ctc_pkg.sv
// Shared types, constants and saturating Q16.16 arithmetic for the transform.
`default_nettype none
package ctc_pkg;

  // quotient bits of the reciprocal dividers (numerator up to 2^33)
  localparam int DIV_QW = 34;
  localparam logic [DIV_QW-1:0] NUM_ONE = 34'h1_0000_0000;
  localparam logic [DIV_QW-1:0] NUM_TWO = 34'h2_0000_0000;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_MAX = 32'sh7fffffff;
  localparam q_t Q_MIN = 32'sh80000000;
  localparam logic signed [63:0] W_MAX = 64'sd2147483647;
  localparam logic signed [63:0] W_MIN = -64'sd2147483648;

  typedef struct packed {
    logic sat;
    q_t   v;
  } qres_t;

  // one item as it moves down the pipe
  typedef struct packed {
    logic mode;
    logic last;
    logic sat;
    logic dz;
    q_t r1; q_t r2; q_t r3; q_t r4; q_t r5;
    q_t kx; q_t ky; q_t kz;
    q_t lx; q_t ly; q_t lz;
    q_t mx; q_t my; q_t mz;
    q_t c; q_t rho; q_t ub; q_t xm2a; q_t eig2; q_t eig3;
    q_t radd; q_t rsub; q_t sub2; q_t sub3;
    q_t t1; q_t g; q_t t2; q_t t3; q_t tc; q_t cc;
    q_t fplus; q_t fmins; q_t den; q_t t5p; q_t fsum;
    q_t mf4; q_t mf5; q_t spre; q_t diff; q_t s; q_t tcd; q_t t5;
    q_t o1; q_t o5;
    q_t pl2; q_t pm2; q_t pk2;
    q_t pl3; q_t pm3; q_t pk3;
    q_t pl4; q_t pm4; q_t pk4;
    q_t a2; q_t a3; q_t a4;
  } ctc_pipe_t;

  function automatic qres_t sat64(input logic signed [63:0] x);
    qres_t r;
    if (x > W_MAX) begin
      r.sat = 1'b1;
      r.v   = Q_MAX;
    end else if (x < W_MIN) begin
      r.sat = 1'b1;
      r.v   = Q_MIN;
    end else begin
      r.sat = 1'b0;
      r.v   = x[31:0];
    end
    return r;
  endfunction

  function automatic qres_t qadd(input q_t a, input q_t b);
    return sat64(64'(a) + 64'(b));
  endfunction

  function automatic qres_t qsub(input q_t a, input q_t b);
    return sat64(64'(a) - 64'(b));
  endfunction

  function automatic qres_t qneg(input q_t a);
    return sat64(64'sd0 - 64'(a));
  endfunction

  // round to nearest, halves up: floor((a*b + 2^15) / 2^16)
  function automatic qres_t qmul(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd32768;
    return sat64(p >>> 16);
  endfunction

endpackage
`default_nettype wire

// File: rtl/ctc_div.sv
// Pipelined restoring divider: saturated Q16.16 quotient of a positive numerator by signed lanes.
`default_nettype none
module ctc_div import ctc_pkg::*; #(
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [DIV_QW-1:0] in_num,
  input  q_t                     in_den [LANES],
  input  wire logic [PW-1:0]     in_pay,
  output logic                   out_valid,
  output q_t                     out_quo [LANES],
  output logic                   out_sat [LANES],
  output logic                   out_zero [LANES],
  output logic [PW-1:0]          out_pay
);

  logic              vld  [DIV_QW+1];
  logic [PW-1:0]     pay  [DIV_QW+1];
  logic [DIV_QW-1:0] qn   [DIV_QW+1][LANES];
  logic [31:0]       rem  [DIV_QW+1][LANES];
  logic [31:0]       dmag [DIV_QW+1][LANES];
  logic              neg  [DIV_QW+1][LANES];
  logic              zero [DIV_QW+1][LANES];

  // setup: magnitude and sign of each divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay[0] <= in_pay;
      for (int l = 0; l < LANES; l++) begin
        qn[0][l]   <= in_num;
        rem[0][l]  <= '0;
        dmag[0][l] <= in_den[l][31] ? (32'd0 - in_den[l]) : in_den[l];
        neg[0][l]  <= in_den[l][31];
        zero[0][l] <= (in_den[l] == '0);
      end
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= DIV_QW; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pay[k] <= pay[k-1];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [32:0] shl;
      logic [32:0] trial;

      assign shl   = {rem[k-1][l], qn[k-1][l][DIV_QW-1]};
      assign trial = shl - {1'b0, dmag[k-1][l]};

      always_ff @(posedge clk) begin
        if (en) begin
          if (trial[32]) begin
            rem[k][l] <= shl[31:0];
            qn[k][l]  <= {qn[k-1][l][DIV_QW-2:0], 1'b0};
          end else begin
            rem[k][l] <= trial[31:0];
            qn[k][l]  <= {qn[k-1][l][DIV_QW-2:0], 1'b1};
          end
          dmag[k][l] <= dmag[k-1][l];
          neg[k][l]  <= neg[k-1][l];
          zero[k][l] <= zero[k-1][l];
        end
      end
    end
  end

  // sign, saturation and zero-divisor handling
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[DIV_QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pay <= pay[DIV_QW];
      for (int l = 0; l < LANES; l++) begin
        if (zero[DIV_QW][l]) begin
          out_quo[l]  <= '0;
          out_sat[l]  <= 1'b0;
          out_zero[l] <= 1'b1;
        end else if (!neg[DIV_QW][l]) begin
          out_zero[l] <= 1'b0;
          if (qn[DIV_QW][l][DIV_QW-1:31] != '0) begin
            out_quo[l] <= Q_MAX;
            out_sat[l] <= 1'b1;
          end else begin
            out_quo[l] <= qn[DIV_QW][l][31:0];
            out_sat[l] <= 1'b0;
          end
        end else begin
          out_zero[l] <= 1'b0;
          if (qn[DIV_QW][l] > {{(DIV_QW-32){1'b0}}, 32'h8000_0000}) begin
            out_quo[l] <= Q_MIN;
            out_sat[l] <= 1'b1;
          end else begin
            out_quo[l] <= 32'd0 - qn[DIV_QW][l][31:0];
            out_sat[l] <= 1'b0;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/characteristic_to_conserved_transform.sv
// Throughput: one point per cycle; the whole pipe advances unless the output beat is stalled.
// Depth is set by the two reciprocal dividers (1/rho with 1/xm2a, then 2/fsum), each 36 stages:
// setup, 34 quotient bits and the sign/saturation register.
// Reset (rst, synchronous) clears all valid bits and sets precondition mode to plain.
`default_nettype none
`include "characteristic_to_conserved_transform_defines.svh"
module characteristic_to_conserved_transform import ctc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        precondition_mode,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] residual_one_two,
  input  wire logic [63:0] residual_three_four,
  input  q_t               residual_five,
  input  wire logic [63:0] metric_k_xy,
  input  wire logic [63:0] metric_kz_lx,
  input  wire logic [63:0] metric_l_yz,
  input  wire logic [63:0] metric_m_xy,
  input  q_t               metric_m_z,
  input  wire logic [63:0] sound_and_density,
  input  wire logic [63:0] convective_and_mach_factor,
  input  wire logic [63:0] eigen_two_three,
  input  wire logic        last_point,
  output logic             out_valid,
  input  wire logic        out_stall,
  output q_t               out_one,
  output q_t               out_two,
  output q_t               out_three,
  output q_t               out_four,
  output q_t               out_five,
  output logic [1:0]       error_status,
  output logic             last_point_out
);

  localparam int PW = $bits(ctc_pipe_t);

  logic en;
  logic precond;

  ctc_pipe_t s0, s0_next, s1, s1_next, s3, s3_next, s4, s4_next;
  ctc_pipe_t s6, s6_next, s7, s7_next, s8, s8_next, s9, s9_next;
  ctc_pipe_t s10, s10_next, s11, s11_next, da_item, db_item;
  logic v0, v1, v3, v4, v6, v7, v8, v9, v10, v11;

  q_t da_den [2];
  q_t da_quo [2];
  logic da_sat [2];
  logic da_zero [2];
  logic da_valid;
  logic [PW-1:0] da_pay;

  q_t db_den [1];
  q_t db_quo [1];
  logic db_sat [1];
  logic db_zero [1];
  logic db_valid;
  logic [PW-1:0] db_pay;

  // whole pipe moves unless the output beat is held
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      precond <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      precond <= precondition_mode;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v6 <= 1'b0;
      v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0; v11 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid; v1 <= v0; v3 <= da_valid; v4 <= v3; v6 <= db_valid;
      v7 <= v6; v8 <= v7; v9 <= v8; v10 <= v9; v11 <= v10;
      out_valid <= v11;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= s0_next; s1 <= s1_next; s3 <= s3_next; s4 <= s4_next;
      s6 <= s6_next; s7 <= s7_next; s8 <= s8_next; s9 <= s9_next;
      s10 <= s10_next; s11 <= s11_next;
    end
  end

  // input capture: unpack words
  always_comb begin
    s0_next      = '0;
    s0_next.mode = precond;
    s0_next.last = last_point;
    s0_next.r1   = residual_one_two[63:32];
    s0_next.r2   = residual_one_two[31:0];
    s0_next.r3   = residual_three_four[63:32];
    s0_next.r4   = residual_three_four[31:0];
    s0_next.r5   = residual_five;
    s0_next.kx   = metric_k_xy[63:32];
    s0_next.ky   = metric_k_xy[31:0];
    s0_next.kz   = metric_kz_lx[63:32];
    s0_next.lx   = metric_kz_lx[31:0];
    s0_next.ly   = metric_l_yz[63:32];
    s0_next.lz   = metric_l_yz[31:0];
    s0_next.mx   = metric_m_xy[63:32];
    s0_next.my   = metric_m_xy[31:0];
    s0_next.mz   = metric_m_z;
    s0_next.c    = sound_and_density[63:32];
    s0_next.rho  = sound_and_density[31:0];
    s0_next.ub   = convective_and_mach_factor[63:32];
    s0_next.xm2a = convective_and_mach_factor[31:0];
    s0_next.eig2 = eigen_two_three[63:32];
    s0_next.eig3 = eigen_two_three[31:0];
  end

  // residual sum/difference and eigenvalue offsets
  always_comb begin
    qres_t a, b, e2, e3;
    s1_next = s0;
    a  = qadd(s0.r4, s0.r5);
    b  = qsub(s0.r4, s0.r5);
    e2 = qsub(s0.eig2, s0.ub);
    e3 = qsub(s0.eig3, s0.ub);
    s1_next.radd = a.v;
    s1_next.rsub = b.v;
    s1_next.sub2 = e2.v;
    s1_next.sub3 = e3.v;
    s1_next.sat  = s0.sat | a.sat | (b.sat & !s0.mode) | ((e2.sat | e3.sat) & s0.mode);
  end

  // 1/rho and 1/xm2a
  assign da_den[0] = s1.rho;
  assign da_den[1] = s1.xm2a;

  ctc_div #(.LANES(2), .PW(PW)) u_div_a (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v1),
    .in_num   (NUM_ONE),
    .in_den   (da_den),
    .in_pay   (s1),
    .out_valid(da_valid),
    .out_quo  (da_quo),
    .out_sat  (da_sat),
    .out_zero (da_zero),
    .out_pay  (da_pay)
  );

  assign da_item = ctc_pipe_t'(da_pay);

  // products of the reciprocals, and c squared
  always_comb begin
    qres_t m2, m3, mc, mcc, mp, mm;
    s3_next     = da_item;
    s3_next.t1  = da_quo[0];
    s3_next.g   = da_quo[1];
    s3_next.dz  = da_item.dz | da_zero[0] | (da_zero[1] & da_item.mode);
    m2  = qmul(da_quo[0], da_item.r2);
    m3  = qmul(da_quo[0], da_item.r3);
    mc  = qmul(da_quo[0], da_item.c);
    mcc = qmul(da_item.c, da_item.c);
    mp  = qmul(da_item.sub2, da_quo[1]);
    mm  = qmul(da_item.sub3, da_quo[1]);
    s3_next.t2    = m2.v;
    s3_next.t3    = m3.v;
    s3_next.tc    = mc.v;
    s3_next.cc    = mcc.v;
    s3_next.fplus = mp.v;
    s3_next.fmins = mm.v;
    s3_next.sat   = da_item.sat | da_sat[0] | m2.sat | m3.sat | mc.sat | mcc.sat |
                    ((da_sat[1] | mp.sat | mm.sat) & da_item.mode);
  end

  // plain t5, negate fmins, denominator of fsum
  always_comb begin
    qres_t p5, ng, d;
    s4_next = s3;
    p5 = qmul(s3.tc, s3.rsub);
    ng = qneg(s3.fmins);
    d  = qadd(s3.fplus, ng.v);
    s4_next.t5p   = p5.v;
    s4_next.fmins = ng.v;
    s4_next.den   = d.v;
    s4_next.sat   = s3.sat | (p5.sat & !s3.mode) | ((ng.sat | d.sat) & s3.mode);
  end

  // 2/(fplus + fmins)
  assign db_den[0] = s4.den;

  ctc_div #(.LANES(1), .PW(PW)) u_div_b (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .in_num   (NUM_TWO),
    .in_den   (db_den),
    .in_pay   (s4),
    .out_valid(db_valid),
    .out_quo  (db_quo),
    .out_sat  (db_sat),
    .out_zero (db_zero),
    .out_pay  (db_pay)
  );

  assign db_item = ctc_pipe_t'(db_pay);

  // scaled residual terms
  always_comb begin
    qres_t m4, m5, sp;
    s6_next      = db_item;
    s6_next.fsum = db_quo[0];
    s6_next.dz   = db_item.dz | (db_zero[0] & db_item.mode);
    m4 = qmul(db_item.fmins, db_item.r4);
    m5 = qmul(db_item.fplus, db_item.r5);
    sp = qmul(db_item.radd, db_quo[0]);
    s6_next.mf4  = m4.v;
    s6_next.mf5  = m5.v;
    s6_next.spre = sp.v;
    s6_next.sat  = db_item.sat | ((db_sat[0] | m4.sat | m5.sat | sp.sat) & db_item.mode);
  end

  // difference and choice of s
  always_comb begin
    qres_t df;
    s7_next = s6;
    df = qsub(s6.mf4, s6.mf5);
    s7_next.diff = df.v;
    s7_next.s    = s6.mode ? s6.spre : s6.radd;
    s7_next.sat  = s6.sat | (df.sat & s6.mode);
  end

  always_comb begin
    qres_t m;
    s8_next = s7;
    m = qmul(s7.tc, s7.diff);
    s8_next.tcd = m.v;
    s8_next.sat = s7.sat | (m.sat & s7.mode);
  end

  // final t5 and out1
  always_comb begin
    qres_t m, a;
    s9_next = s8;
    m = qmul(s8.tcd, s8.fsum);
    a = qadd(s8.r1, s8.s);
    s9_next.t5  = s8.mode ? m.v : s8.t5p;
    s9_next.o1  = a.v;
    s9_next.sat = s8.sat | a.sat | (m.sat & s8.mode);
  end

  // metric products and out5
  always_comb begin
    qres_t m5, l2, n2, k2, l3, n3, k3, l4, n4, k4;
    s10_next = s9;
    m5 = qmul(s9.cc, s9.s);
    l2 = qmul(s9.lx, s9.t2);
    n2 = qmul(s9.mx, s9.t3);
    k2 = qmul(s9.kx, s9.t5);
    l3 = qmul(s9.ly, s9.t2);
    n3 = qmul(s9.my, s9.t3);
    k3 = qmul(s9.ky, s9.t5);
    l4 = qmul(s9.lz, s9.t2);
    n4 = qmul(s9.mz, s9.t3);
    k4 = qmul(s9.kz, s9.t5);
    s10_next.o5  = m5.v;
    s10_next.pl2 = l2.v; s10_next.pm2 = n2.v; s10_next.pk2 = k2.v;
    s10_next.pl3 = l3.v; s10_next.pm3 = n3.v; s10_next.pk3 = k3.v;
    s10_next.pl4 = l4.v; s10_next.pm4 = n4.v; s10_next.pk4 = k4.v;
    s10_next.sat = s9.sat | m5.sat | l2.sat | n2.sat | k2.sat | l3.sat | n3.sat |
                   k3.sat | l4.sat | n4.sat | k4.sat;
  end

  // first partial sums
  always_comb begin
    qres_t a2, a3, a4;
    s11_next = s10;
    a2 = qadd(s10.pl2, s10.pm2);
    a3 = qadd(s10.pl3, s10.pm3);
    a4 = qadd(s10.pl4, s10.pm4);
    s11_next.a2  = a2.v;
    s11_next.a3  = a3.v;
    s11_next.a4  = a4.v;
    s11_next.sat = s10.sat | a2.sat | a3.sat | a4.sat;
  end

  // final sums, status and output register
  always_ff @(posedge clk) begin
    qres_t o2, o3, o4;
    o2 = qadd(s11.a2, s11.pk2);
    o3 = qadd(s11.a3, s11.pk3);
    o4 = qadd(s11.a4, s11.pk4);
    if (en) begin
      last_point_out <= s11.last;
      if (s11.dz) begin
        out_one      <= '0;
        out_two      <= '0;
        out_three    <= '0;
        out_four     <= '0;
        out_five     <= '0;
        error_status <= ST_DIV0;
      end else begin
        out_one      <= s11.o1;
        out_two      <= o2.v;
        out_three    <= o3.v;
        out_four     <= o4.v;
        out_five     <= s11.o5;
        error_status <= (s11.sat | o2.sat | o3.sat | o4.sat) ? ST_SAT : ST_OK;
      end
    end
  end

  // checks
  `CTC_ASSERT_IMP(a_div0_zeroes, out_valid && error_status == ST_DIV0, out_one == '0 && out_two == '0 && out_three == '0 && out_four == '0 && out_five == '0, "division-by-zero beat carries nonzero data")
  `CTC_ASSERT_IMP(a_status_code, out_valid, error_status == ST_OK || error_status == ST_DIV0 || error_status == ST_SAT, "illegal status code")
  `CTC_ASSERT_NXT(a_stall_freeze, out_valid && out_stall, $stable(v11) && $stable(s11.o1) && $stable(db_valid), "pipe moved while output held")

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the characteristic-to-conserved transform block.
`default_nettype none
module testbench import ctc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 82;
  localparam int RANDOM_PTS  = 2000;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [63:0] r12, r34, k_xy, kz_lx, l_yz, m_xy, c_rho, ub_xm, eig;
    logic [31:0] r5, mz;
    logic        last;
  } point_t;

  typedef struct {
    logic [31:0] o1, o2, o3, o4, o5;
    logic [1:0]  status;
    logic        last;
  } cons_t;

  // directed row: point, mode, and an optional typed-in result
  typedef struct {
    point_t pt;
    logic   mode;
    logic   has_fixed;
    cons_t  fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_mode = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [63:0] residual_one_two = '0, residual_three_four = '0, metric_k_xy = '0;
  logic [63:0] metric_kz_lx = '0, metric_l_yz = '0, metric_m_xy = '0;
  logic [63:0] sound_and_density = '0, convective_and_mach_factor = '0;
  logic [63:0] eigen_two_three = '0;
  q_t residual_five = '0, metric_m_z = '0;
  logic last_point = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  q_t out_one, out_two, out_three, out_four, out_five;
  logic [1:0] error_status;
  logic last_point_out;

  characteristic_to_conserved_transform u_top (
    .clk, .rst, .cfg_valid, .cfg_ready, .precondition_mode(cfg_mode),
    .in_valid, .in_stall, .residual_one_two, .residual_three_four, .residual_five,
    .metric_k_xy, .metric_kz_lx, .metric_l_yz, .metric_m_xy, .metric_m_z,
    .sound_and_density, .convective_and_mach_factor, .eigen_two_three, .last_point,
    .out_valid, .out_stall, .out_one, .out_two, .out_three, .out_four, .out_five,
    .error_status, .last_point_out
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  logic  mode_shadow = 1'b0;
  logic  sat_seen, dz_seen;
  cons_t pending_cons[$];
  int    errors = 0;
  int    beats_out = 0;
  int    n_status[3] = '{0, 0, 0};
  int    cycles = 0;
  logic  long_hold = 1'b0;

  function automatic longint clampw(longint v);
    if (v > 64'sd2147483647) begin
      sat_seen = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat_seen = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clampw(a + b);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    return clampw(a - b);
  endfunction

  // product rounded to nearest, halves upward
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b + 32768;
    return clampw(p >>> 16);
  endfunction

  // quotient truncated toward zero
  function automatic longint fx_div(longint a, longint b);
    if (b == 0) begin
      dz_seen = 1'b1;
      return 0;
    end
    return clampw((a * 65536) / b);
  endfunction

  function automatic longint hi_of(logic [63:0] w);
    return longint'($signed(w[63:32]));
  endfunction

  function automatic longint lo_of(logic [63:0] w);
    return longint'($signed(w[31:0]));
  endfunction

  function automatic cons_t to_conserved(point_t p, logic pre);
    longint r1, r2, r3, r4, r5, kx, ky, kz, lx, ly, lz, mx, my, mz;
    longint c, rho, ub, xm, e2, e3, t1, t2, t3, t5, s, g, fp, fm, fs, d;
    longint o1, o2, o3, o4, o5;
    cons_t  r;
    sat_seen = 1'b0;
    dz_seen  = 1'b0;
    r1 = hi_of(p.r12);   r2 = lo_of(p.r12);
    r3 = hi_of(p.r34);   r4 = lo_of(p.r34);
    r5 = longint'($signed(p.r5));
    kx = hi_of(p.k_xy);  ky = lo_of(p.k_xy);
    kz = hi_of(p.kz_lx); lx = lo_of(p.kz_lx);
    ly = hi_of(p.l_yz);  lz = lo_of(p.l_yz);
    mx = hi_of(p.m_xy);  my = lo_of(p.m_xy);
    mz = longint'($signed(p.mz));
    c  = hi_of(p.c_rho); rho = lo_of(p.c_rho);
    ub = hi_of(p.ub_xm); xm = lo_of(p.ub_xm);
    e2 = hi_of(p.eig);   e3 = lo_of(p.eig);
    t1 = fx_div(65536, rho);
    t2 = fx_mul(t1, r2);
    t3 = fx_mul(t1, r3);
    if (!pre) begin
      t5 = fx_mul(fx_mul(t1, c), fx_sub(r4, r5));
      s  = fx_add(r4, r5);
    end else begin
      g  = fx_div(65536, xm);
      fp = fx_mul(fx_sub(e2, ub), g);
      fm = clampw(-fx_mul(fx_sub(e3, ub), g));
      fs = fx_div(131072, fx_add(fp, fm));
      d  = fx_sub(fx_mul(fm, r4), fx_mul(fp, r5));
      t5 = fx_mul(fx_mul(fx_mul(t1, c), d), fs);
      s  = fx_mul(fx_add(r4, r5), fs);
    end
    o1 = fx_add(r1, s);
    o5 = fx_mul(fx_mul(c, c), s);
    o2 = fx_add(fx_add(fx_mul(lx, t2), fx_mul(mx, t3)), fx_mul(kx, t5));
    o3 = fx_add(fx_add(fx_mul(ly, t2), fx_mul(my, t3)), fx_mul(ky, t5));
    o4 = fx_add(fx_add(fx_mul(lz, t2), fx_mul(mz, t3)), fx_mul(kz, t5));
    if (dz_seen) begin
      o1 = 0; o2 = 0; o3 = 0; o4 = 0; o5 = 0;
      r.status = ST_DIV0;
    end else if (sat_seen) begin
      r.status = ST_SAT;
    end else begin
      r.status = ST_OK;
    end
    r.o1 = o1[31:0]; r.o2 = o2[31:0]; r.o3 = o3[31:0];
    r.o4 = o4[31:0]; r.o5 = o5[31:0];
    r.last = p.last;
    return r;
  endfunction

  function automatic logic [63:0] pack2(logic [31:0] a, logic [31:0] b);
    return {a, b};
  endfunction

  // well-conditioned point: moderate values, nonzero divisors
  function automatic point_t tame_point();
    point_t p;
    logic [31:0] w[22];
    for (int i = 0; i < 22; i++) w[i] = $urandom_range(0, 32'h3_0000) - 32'h1_8000;
    p.r12 = pack2(w[0], w[1]);   p.r34 = pack2(w[2], w[3]);  p.r5 = w[4];
    p.k_xy = pack2(w[5], w[6]);  p.kz_lx = pack2(w[7], w[8]);
    p.l_yz = pack2(w[9], w[10]); p.m_xy = pack2(w[11], w[12]); p.mz = w[13];
    p.c_rho = pack2($urandom_range(32'h100, 32'h4_0000), $urandom_range(32'h800, 32'h4_0000));
    p.ub_xm = pack2(w[14], $urandom_range(32'h800, 32'h2_0000));
    p.eig = pack2(w[15] + 32'h4_0000, w[16] - 32'h4_0000);
    p.last = 1'($urandom_range(0, 1));
    return p;
  endfunction

  // fully random point: every bit of every field toggles; rho and xm2a each forced to zero one time in sixteen
  function automatic point_t wild_point();
    point_t p;
    p.r12 = {$urandom, $urandom};  p.r34 = {$urandom, $urandom}; p.r5 = $urandom;
    p.k_xy = {$urandom, $urandom}; p.kz_lx = {$urandom, $urandom};
    p.l_yz = {$urandom, $urandom}; p.m_xy = {$urandom, $urandom}; p.mz = $urandom;
    p.c_rho = {$urandom, $urandom}; p.ub_xm = {$urandom, $urandom};
    p.eig = {$urandom, $urandom};
    p.last = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 15) == 0) p.c_rho[31:0] = '0;
    if ($urandom_range(0, 15) == 0) p.ub_xm[31:0] = '0;
    return p;
  endfunction

  task automatic send_point(point_t p);
    residual_one_two <= p.r12; residual_three_four <= p.r34; residual_five <= p.r5;
    metric_k_xy <= p.k_xy; metric_kz_lx <= p.kz_lx; metric_l_yz <= p.l_yz;
    metric_m_xy <= p.m_xy; metric_m_z <= p.mz; sound_and_density <= p.c_rho;
    convective_and_mach_factor <= p.ub_xm; eigen_two_three <= p.eig;
    last_point <= p.last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_cons.push_back(to_conserved(p, mode_shadow));
  endtask

  // drop valid for a random gap between bursts
  task automatic burst_gap(ref int left);
    if (left > 0) begin
      left--;
    end else begin
      left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic set_mode(logic m);
    while (pending_cons.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_mode  <= m;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    mode_shadow = m;
  endtask

  // typed-in result of a directed row against the predictor
  task automatic check_fixed(int idx, cons_t ex, cons_t act);
    if (act.o1 !== ex.o1) begin
      $error("row %0d out_one exp %h got %h", idx, ex.o1, act.o1); errors++;
    end
    if (act.o2 !== ex.o2) begin
      $error("row %0d out_two exp %h got %h", idx, ex.o2, act.o2); errors++;
    end
    if (act.o3 !== ex.o3) begin
      $error("row %0d out_three exp %h got %h", idx, ex.o3, act.o3); errors++;
    end
    if (act.o4 !== ex.o4) begin
      $error("row %0d out_four exp %h got %h", idx, ex.o4, act.o4); errors++;
    end
    if (act.o5 !== ex.o5) begin
      $error("row %0d out_five exp %h got %h", idx, ex.o5, act.o5); errors++;
    end
    if (act.status !== ex.status) begin
      $error("row %0d error_status exp %0d got %0d", idx, ex.status, act.status); errors++;
    end
    if (act.last !== ex.last) begin
      $error("row %0d last_point_out exp %b got %b", idx, ex.last, act.last); errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    cons_t e;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (pending_cons.size() == 0) begin
        $error("unexpected output beat");
        errors++;
      end else begin
        e = pending_cons.pop_front();
        beats_out++;
        if (error_status < 3) n_status[error_status]++;
        if (out_one !== e.o1) begin
          $error("out_one exp %h got %h", e.o1, out_one); errors++;
        end
        if (out_two !== e.o2) begin
          $error("out_two exp %h got %h", e.o2, out_two); errors++;
        end
        if (out_three !== e.o3) begin
          $error("out_three exp %h got %h", e.o3, out_three); errors++;
        end
        if (out_four !== e.o4) begin
          $error("out_four exp %h got %h", e.o4, out_four); errors++;
        end
        if (out_five !== e.o5) begin
          $error("out_five exp %h got %h", e.o5, out_five); errors++;
        end
        if (error_status !== e.status) begin
          $error("error_status exp %0d got %0d", e.status, error_status); errors++;
        end
        if (last_point_out !== e.last) begin
          $error("last_point_out exp %b got %b", e.last, last_point_out); errors++;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < 300; hold++) @(posedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (cycles % 512 < 128) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  row_t rows[$];

  task automatic add_row(point_t p, logic m, logic fixed_on, cons_t fx);
    row_t r;
    r.pt = p; r.mode = m; r.has_fixed = fixed_on; r.fixed = fx;
    rows.push_back(r);
  endtask

  initial begin
    point_t p;
    cons_t  z, got;
    int     left;
    z = '{default: '0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows: all-zero point (rho zero), extremes, unit cases
    p = '{default: '0};
    z.status = ST_DIV0;
    add_row(p, 1'b0, 1'b1, z);
    p.last = 1'b1; z.last = 1'b1;
    add_row(p, 1'b1, 1'b1, z);
    // rho = 1, all else zero: plain gives zeros, ok
    p = '{default: '0};
    p.c_rho = 64'h0000_0000_0001_0000;
    z = '{default: '0};
    add_row(p, 1'b0, 1'b1, z);
    // preconditioned with xm2a zero
    z.status = ST_DIV0;
    add_row(p, 1'b1, 1'b1, z);
    // max residual one plus max residual four saturates
    p.r12 = 64'h7fff_ffff_0000_0000;
    p.r34 = 64'h0000_0000_7fff_ffff;
    add_row(p, 1'b0, 1'b0, z);
    // all ones and extremes
    p = '{default: '1};
    add_row(p, 1'b0, 1'b0, z);
    add_row(p, 1'b1, 1'b0, z);
    p = '{r12: 64'h8000_0000_8000_0000, r34: 64'h8000_0000_7fff_ffff,
          r5: 32'h8000_0000, k_xy: 64'h7fff_ffff_8000_0000,
          kz_lx: 64'h8000_0000_7fff_ffff, l_yz: 64'h7fff_ffff_7fff_ffff,
          m_xy: 64'h8000_0000_8000_0000, mz: 32'h7fff_ffff,
          c_rho: 64'h7fff_ffff_0000_0001, ub_xm: 64'h8000_0000_0000_0001,
          eig: 64'h7fff_ffff_8000_0000, last: 1'b1};
    add_row(p, 1'b0, 1'b0, z);
    add_row(p, 1'b1, 1'b0, z);
    // preconditioned with eig2 == eig3 == ub: fplus + fmins is zero
    p = tame_point();
    p.eig = {p.ub_xm[63:32], p.ub_xm[63:32]};
    z.last = p.last;
    add_row(p, 1'b1, 1'b1, z);
    for (int i = 0; i < 6; i++) add_row(tame_point(), i[0], 1'b0, z);

    // plain rows first, then preconditioned
    for (int m = 0; m < 2; m++) begin
      if (m == 1) set_mode(1'b1);
      foreach (rows[i]) begin
        if (rows[i].mode == m[0]) begin
          send_point(rows[i].pt);
          if (rows[i].has_fixed) begin
            got = pending_cons[$];
            check_fixed(i, rows[i].fixed, got);
          end
        end
      end
      in_valid <= 1'b0;
    end

    // random part in four phases, mode alternating; hold-off during the second
    left = 0;
    for (int ph = 0; ph < 4; ph++) begin
      set_mode(ph[0] ? 1'b0 : 1'b1);
      if (ph == 1) long_hold = 1'b1;
      for (int i = 0; i < RANDOM_PTS / 4; i++) begin
        send_point(($urandom_range(0, 9) < 7) ? tame_point() : wild_point());
        burst_gap(left);
      end
      in_valid <= 1'b0;
    end

    while (pending_cons.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d points in both modes: %0d ok, %0d divide-by-zero, %0d saturated",
             beats_out, n_status[0], n_status[1], n_status[2]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
